/* rtl/mtl_pkg.sv */
// Package for the MAC address table: sizes, action and status codes,
// and the request, response, memory entry and scan summary types.
// Has no dependencies. mtl_scan and mac_table_lru_with_pinning use it.
`default_nettype none

package mtl_pkg;

  // Table geometry and field widths.
  localparam int ENTRIES   = 16;
  localparam int SLOT_W    = $clog2(ENTRIES);
  localparam int CNT_W     = $clog2(ENTRIES + 1);
  localparam int MAC_W     = 48;
  localparam int TYPE_W    = 8;
  localparam int TIME_BITS = 32;
  localparam int NOW_W     = 32;
  localparam int IDX_W     = 4;

  // Request actions.
  localparam logic [1:0] ACT_LOOKUP  = 2'd0;
  localparam logic [1:0] ACT_INSTALL = 2'd1;
  localparam logic [1:0] ACT_FORGET  = 2'd2;

  // Response status codes.
  localparam logic [2:0] STAT_FOUND     = 3'd0;
  localparam logic [2:0] STAT_NEW_FREE  = 3'd1;
  localparam logic [2:0] STAT_NEW_EVICT = 3'd2;
  localparam logic [2:0] STAT_FULL      = 3'd3;
  localparam logic [2:0] STAT_INVALID   = 3'd4;

  typedef logic [TIME_BITS-1:0] time_t;
  typedef logic [SLOT_W-1:0]    slot_idx_t;

  typedef struct packed {
    logic [1:0]       action;
    logic [MAC_W-1:0] mac;
    logic [7:0]       device_type;
    logic [IDX_W-1:0] entry_index;
    logic [NOW_W-1:0] now;
  } req_t;

  typedef struct packed {
    logic [3:0] slot;
    logic [2:0] status;
    logic [7:0] slot_type;
  } rsp_t;

  // One word of the entry memory.
  typedef struct packed {
    logic [MAC_W-1:0]  address;
    logic [TYPE_W-1:0] kind;
    time_t             last_seen;
  } entry_t;

  // Summary of one pass over the table.
  typedef struct packed {
    logic              hit;
    slot_idx_t         hit_idx;
    logic [TYPE_W-1:0] hit_kind;
    logic              free;
    slot_idx_t         free_idx;
    logic              pick;
    slot_idx_t         pick_idx;
  } scan_t;

endpackage

`default_nettype wire

/* rtl/mtl_ram.sv */
// Generic single-port-write, single-port-read synchronous RAM.
// Read data is registered. No dependencies.
`default_nettype none

module mtl_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 88
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* rtl/mtl_scan.sv */
// Scan accumulator: watches the entry words streaming out of the memory
// and keeps the first hit, the first free slot and the LRU victim. Uses mtl_pkg.
`default_nettype none

module mtl_scan (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     start,
  input  wire logic                     vld,
  input  wire mtl_pkg::slot_idx_t       idx,
  input  wire mtl_pkg::entry_t          entry,
  input  wire logic                     used,
  input  wire logic                     pinned,
  input  wire logic [mtl_pkg::MAC_W-1:0] mac,
  output mtl_pkg::scan_t                result
);

  import mtl_pkg::*;

  time_t pick_time;

  // Fold one valid entry per cycle into the running summary.
  always_ff @(posedge clk) begin
    if (rst || start) begin
      result.hit  <= 1'b0;
      result.free <= 1'b0;
      result.pick <= 1'b0;
    end else if (vld) begin
      // First used entry holding the requested address.
      if (used && (entry.address == mac) && !result.hit) begin
        result.hit      <= 1'b1;
        result.hit_idx  <= idx;
        result.hit_kind <= entry.kind;
      end
      // Lowest unused slot.
      if (!used && !result.free) begin
        result.free     <= 1'b1;
        result.free_idx <= idx;
      end
      // Oldest unpinned entry; a strict compare keeps the lowest index on a tie.
      if (!pinned && (!result.pick || (entry.last_seen < pick_time))) begin
        result.pick     <= 1'b1;
        result.pick_idx <= idx;
        pick_time       <= entry.last_seen;
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/mac_table_lru_with_pinning.sv */
// MAC address table with LRU eviction and pinned entries; uses mtl_pkg, mtl_ram, mtl_scan.
// Sequence: a lookup reads all 16 slots through the single read port of the entry memory,
// then resolves and registers its response; install and forget read the addressed slot,
// then update its flags; an invalid request goes straight to the finish step. One request
// is in flight at a time: the next request can be accepted in the cycle after the response is registered.
// Reset clears the used and pinned flags; the entry memory is not cleared.
`default_nettype none

module mac_table_lru_with_pinning (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output logic               req_stall,
  input  wire mtl_pkg::req_t req,
  output logic               rsp_valid,
  input  wire logic          rsp_stall,
  output mtl_pkg::rsp_t      rsp
);

  import mtl_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN   = 3'd1;
  localparam logic [2:0] S_DECIDE = 3'd2;
  localparam logic [2:0] S_IDXRD  = 3'd3;
  localparam logic [2:0] S_IDXDAT = 3'd4;
  localparam logic [2:0] S_FIN    = 3'd5;

  logic [2:0]         state;
  req_t               req_q;
  logic [CNT_W-1:0]   cnt;
  logic               rd_vld;
  slot_idx_t          rd_idx;
  logic [ENTRIES-1:0] used;
  logic [ENTRIES-1:0] pinned;
  rsp_t               res;
  rsp_t               dec_rsp;

  logic      ram_we;
  slot_idx_t ram_waddr;
  entry_t    ram_wdata;
  logic      ram_re;
  slot_idx_t ram_raddr;
  entry_t    ram_rdata;
  scan_t     scan;

  logic      req_acc;
  logic      idx_ok;
  slot_idx_t req_slot;
  slot_idx_t q_slot;

  assign req_stall = (state != S_IDLE);
  assign req_acc   = req_valid && !req_stall;
  assign req_slot  = req.entry_index[SLOT_W-1:0];
  assign q_slot    = req_q.entry_index[SLOT_W-1:0];
  assign idx_ok    = (32'(req.entry_index) < ENTRIES) && used[req_slot];

  // Read address: the scan counter during a lookup, the addressed slot for install and forget.
  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = cnt[SLOT_W-1:0];
    case (state)
      S_SCAN: begin
        ram_re = (cnt != CNT_W'(ENTRIES));
      end
      S_IDXRD: begin
        ram_re    = 1'b1;
        ram_raddr = q_slot;
      end
      default: begin
        ram_re = 1'b0;
      end
    endcase
  end

  // Lookup outcome: refresh a hit, else fill a free slot, else evict the LRU entry, else report full.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = scan.hit_idx;
    ram_wdata = '{address: req_q.mac, kind: req_q.device_type,
                  last_seen: time_t'(req_q.now)};
    dec_rsp   = '{slot: 4'd0, status: STAT_FULL, slot_type: 8'd0};
    if (scan.hit) begin
      ram_waddr      = scan.hit_idx;
      ram_wdata.kind = scan.hit_kind;
      dec_rsp        = '{slot: 4'(scan.hit_idx), status: STAT_FOUND,
                         slot_type: scan.hit_kind};
    end else if (scan.free) begin
      ram_waddr = scan.free_idx;
      dec_rsp   = '{slot: 4'(scan.free_idx), status: STAT_NEW_FREE,
                    slot_type: req_q.device_type};
    end else if (scan.pick) begin
      ram_waddr = scan.pick_idx;
      dec_rsp   = '{slot: 4'(scan.pick_idx), status: STAT_NEW_EVICT,
                    slot_type: req_q.device_type};
    end
    if (state == S_DECIDE) begin
      ram_we = scan.hit || scan.free || scan.pick;
    end
  end

  mtl_ram #(
    .DEPTH (ENTRIES),
    .WIDTH ($bits(entry_t))
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  mtl_scan u_scan (
    .clk    (clk),
    .rst    (rst),
    .start  (req_acc),
    .vld    (rd_vld && (state == S_SCAN)),
    .idx    (rd_idx),
    .entry  (ram_rdata),
    .used   (used[rd_idx]),
    .pinned (pinned[rd_idx]),
    .mac    (req_q.mac),
    .result (scan)
  );

  // Sequencer, slot flags and response register. The table is written back before
  // the next request is accepted, so reads never overlap a pending write.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      used      <= '0;
      pinned    <= '0;
      rd_vld    <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      rd_vld <= ram_re;
      // The response register holds until taken; the finish step loads a new one.
      if ((state == S_FIN) && (!rsp_valid || !rsp_stall)) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req_acc) begin
            cnt <= '0;
            if (req.action == ACT_LOOKUP) begin
              state <= S_SCAN;
            end else if ((req.action == ACT_INSTALL || req.action == ACT_FORGET) &&
                         idx_ok) begin
              state <= S_IDXRD;
            end else begin
              res   <= '{slot: 4'd0, status: STAT_INVALID, slot_type: 8'd0};
              state <= S_FIN;
            end
          end
        end
        S_SCAN: begin
          if (ram_re) begin
            cnt <= cnt + CNT_W'(1);
          end
          if (rd_vld && (rd_idx == SLOT_W'(ENTRIES - 1))) begin
            state <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          if (ram_we && !scan.hit) begin
            used[ram_waddr]   <= 1'b1;
            pinned[ram_waddr] <= 1'b0;
          end
          res   <= dec_rsp;
          state <= S_FIN;
        end
        S_IDXRD: begin
          state <= S_IDXDAT;
        end
        S_IDXDAT: begin
          if (req_q.action == ACT_FORGET) begin
            used[q_slot]   <= 1'b0;
            pinned[q_slot] <= 1'b0;
          end else begin
            pinned[q_slot] <= 1'b1;
          end
          res   <= '{slot: 4'(q_slot), status: STAT_FOUND, slot_type: ram_rdata.kind};
          state <= S_FIN;
        end
        S_FIN: begin
          if (!rsp_valid || !rsp_stall) begin
            rsp   <= res;
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Request capture and read index pipeline.
  always_ff @(posedge clk) begin
    rd_idx <= ram_raddr;
    if (req_acc) begin
      req_q <= req;
    end
  end

  // A slot can only be pinned while it is in use.
  a_pin_used: assert property (@(posedge clk) disable iff (rst)
    (pinned & ~used) == '0)
    else $error("pinned slot is not in use");

  // The entry memory is written only when a lookup is resolved.
  a_we_decide: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == S_DECIDE))
    else $error("entry memory written outside resolve step");

  // A lookup is resolved only after every slot has been read.
  a_scan_done: assert property (@(posedge clk) disable iff (rst)
    (state == S_DECIDE) |-> (cnt == CNT_W'(ENTRIES)))
    else $error("lookup resolved before scan completed");

  // Full and invalid responses carry no slot and no type.
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && (rsp.status == STAT_FULL || rsp.status == STAT_INVALID)) |->
    (rsp.slot == 4'd0 && rsp.slot_type == 8'd0))
    else $error("error response with nonzero slot or type");

  // A new response only comes out of the finish step.
  a_rsp_src: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> ($past(state) == S_FIN))
    else $error("response raised outside finish step");

endmodule

`default_nettype wire
